// ===== rtl/fcpg_pkg.sv =====
`default_nettype none

package fcpg_pkg;

    // Screen defaults and sizing
    localparam int DEF_SCREEN_WIDTH  = 240;
    localparam int DEF_SCREEN_HEIGHT = 320;
    localparam int DEF_QUEUE_DEPTH   = 4;

    localparam int COORD_W   = 9;
    localparam int COLOR_W   = 16;
    localparam int RADIUS_W  = 8;
    localparam int CLIP_W    = 18;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 18;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int R2_W      = 2 * RADIUS_W;
    localparam int OUT_DAT_W = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_COLS = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_ROWS = 8'd7;
    localparam logic [CFG_IDX_W-1:0] NUM_REGS      = 8'd8;

    // Fill modes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_INVERSE = 2'd1;
    localparam logic [1:0] MODE_FULL    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [RADIUS_W-1:0] radius;
        logic [COLOR_W-1:0]  fill_color;
        logic [COLOR_W-1:0]  outer_color;
        logic [1:0]          fill_mode;
        logic [CLIP_W-1:0]   clip_columns;
        logic [CLIP_W-1:0]   clip_rows;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
    } win_t;

    typedef struct packed {
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [COLOR_W-1:0]        old;
        logic                      last;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/filled_circle_pixel_generator_core.sv =====
// An accepted input transaction is written to the queue, then registered by the squaring
// stage (stage A) and by the compare stage output register; m_axis stalls back up the queue.
// Throughput: one pixel per clock unless stalled, a transaction per back-end stage per cycle.
// After each configuration write, s_axis_tready drops for one cycle while the window reloads.
// Reset: rst_n clears the queue and the back end; registers take their reset values, the scan
// starts at the top left pixel of the clipped window, and settle_reg holds s_axis_tready low.
`default_nettype none

module filled_circle_pixel_generator_core
    import fcpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // old_pixel[15:0]
    input  wire logic [COLOR_W-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // pixel_x[8:0], pixel_y[17:9], pixel_color[33:18], inside_res[34], zero[39:35]
    output logic [OUT_DAT_W-1:0]       m_axis_tdata,
    // last_of_shape
    output logic                       m_axis_tlast
);

    cfg_t                cfg_reg;
    win_t                win_reg, win_next;
    logic                settle_reg;
    logic                cfg_we;
    logic                push, q_full, q_not_empty, pop;
    item_t               push_item, pop_item;
    logic [COORD_W-1:0]  out_x, out_y;
    logic [COLOR_W-1:0]  out_color;
    logic                out_inside;
    logic signed [DELTA_W:0] lo_x, lo_y;
    logic [DELTA_W-1:0]  hi_x, hi_y;

    assign cfg_ready     = 1'b1;
    assign cfg_we        = cfg_valid && (cfg_index < NUM_REGS);
    assign s_axis_tready = !settle_reg && !q_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.clip_columns <= {COORD_W'(SCREEN_WIDTH - 1), {COORD_W{1'b0}}};
            cfg_reg.clip_rows    <= {COORD_W'(SCREEN_HEIGHT - 1), {COORD_W{1'b0}}};
            settle_reg           <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_valid && cfg_ready;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CENTER_X:  cfg_reg.center_x     <= cfg_data[COORD_W-1:0];
                    REG_CENTER_Y:  cfg_reg.center_y     <= cfg_data[COORD_W-1:0];
                    REG_RADIUS:    cfg_reg.radius       <= cfg_data[RADIUS_W-1:0];
                    REG_FILL:      cfg_reg.fill_color   <= cfg_data[COLOR_W-1:0];
                    REG_BACK:      cfg_reg.outer_color  <= cfg_data[COLOR_W-1:0];
                    REG_MODE:      cfg_reg.fill_mode    <= cfg_data[1:0];
                    REG_CLIP_COLS: cfg_reg.clip_columns <= cfg_data[CLIP_W-1:0];
                    REG_CLIP_ROWS: cfg_reg.clip_rows    <= cfg_data[CLIP_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Clip the bounding box to the margins
    always_comb
    begin
        lo_x = $signed({2'b0, cfg_reg.center_x}) - $signed({3'b0, cfg_reg.radius});
        lo_y = $signed({2'b0, cfg_reg.center_y}) - $signed({3'b0, cfg_reg.radius});
        hi_x = {1'b0, cfg_reg.center_x} + {2'b0, cfg_reg.radius};
        hi_y = {1'b0, cfg_reg.center_y} + {2'b0, cfg_reg.radius};
        if (lo_x < $signed({2'b0, cfg_reg.clip_columns[COORD_W-1:0]}))
            win_next.x0 = cfg_reg.clip_columns[COORD_W-1:0];
        else
            win_next.x0 = lo_x[COORD_W-1:0];
        if (lo_y < $signed({2'b0, cfg_reg.clip_rows[COORD_W-1:0]}))
            win_next.y0 = cfg_reg.clip_rows[COORD_W-1:0];
        else
            win_next.y0 = lo_y[COORD_W-1:0];
        if (hi_x > {1'b0, cfg_reg.clip_columns[CLIP_W-1:COORD_W]})
            win_next.x1 = cfg_reg.clip_columns[CLIP_W-1:COORD_W];
        else
            win_next.x1 = hi_x[COORD_W-1:0];
        if (hi_y > {1'b0, cfg_reg.clip_rows[CLIP_W-1:COORD_W]})
            win_next.y1 = cfg_reg.clip_rows[CLIP_W-1:COORD_W];
        else
            win_next.y1 = hi_y[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    fcpg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .win       (win_reg),
        .restart   (cfg_we),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .old_pixel (s_axis_tdata),
        .push      (push),
        .push_item (push_item)
    );

    fcpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    fcpg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_not_empty),
        .q_item     (pop_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_color  (out_color),
        .out_inside (out_inside),
        .out_last   (m_axis_tlast)
    );

    // Pack the result transaction
    assign m_axis_tdata = {5'b0, out_inside, out_color, out_y, out_x};

endmodule

`default_nettype wire

// ===== rtl/fcpg_front.sv =====
`default_nettype none

module fcpg_front
    import fcpg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire win_t  win,
    input  wire logic  restart,
    input  wire logic  in_valid,
    input  wire logic  in_ready,
    input  wire logic [COLOR_W-1:0] old_pixel,
    output logic       push,
    output item_t      push_item
);

    logic [COORD_W-1:0] scan_col_reg, scan_col_next;
    logic [COORD_W-1:0] scan_row_reg, scan_row_next;
    logic               restart_reg, restart_next;
    logic [COORD_W-1:0] cur_x, cur_y;
    logic               drawing;
    logic               accept;

    // Classify: drawing only with a live mode and a non-empty window
    assign drawing = (cfg.fill_mode != MODE_NONE) && (win.x0 <= win.x1) && (win.y0 <= win.y1);
    assign accept  = in_valid && in_ready;
    assign push    = accept && drawing;

    // Pick the current position, snapping back to the window start
    always_comb
    begin
        if (restart_reg || scan_col_reg < win.x0 || scan_col_reg > win.x1)
            cur_x = win.x0;
        else
            cur_x = scan_col_reg;
        if (restart_reg || scan_row_reg < win.y0 || scan_row_reg > win.y1)
            cur_y = win.y0;
        else
            cur_y = scan_row_reg;
    end

    // Build the item for the back end
    always_comb
    begin
        push_item.x    = cur_x;
        push_item.y    = cur_y;
        push_item.dx   = $signed({1'b0, cur_x}) - $signed({1'b0, cfg.center_x});
        push_item.dy   = $signed({1'b0, cur_y}) - $signed({1'b0, cfg.center_y});
        push_item.old  = old_pixel;
        push_item.last = (cur_x == win.x1) && (cur_y == win.y1);
    end

    // Advance the scan x inner, y outer, wrapping at the last pixel
    always_comb
    begin
        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        restart_next  = restart_reg || restart;
        if (push)
        begin
            restart_next = 1'b0;
            if (cur_x == win.x1)
            begin
                scan_col_next = win.x0;
                scan_row_next = (cur_y == win.y1) ? win.y0 : cur_y + 1'b1;
            end
            else
            begin
                scan_col_next = cur_x + 1'b1;
                scan_row_next = cur_y;
            end
        end
        if (restart)
            restart_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            restart_reg  <= 1'b1;
        end
        else
        begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
            restart_reg  <= restart_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcpg_queue.sv =====
`default_nettype none

module fcpg_queue
    import fcpg_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    output logic       not_empty,
    input  wire logic  pop,
    output item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH)))
        else $error("queue pushed while full");
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");
    a_count_track : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ===== rtl/fcpg_back.sv =====
`default_nettype none

module fcpg_back
    import fcpg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [COLOR_W-1:0] out_color,
    output logic       out_inside,
    output logic       out_last
);

    logic [R2_W-1:0]    r2_reg;
    logic               a_valid_reg, a_valid_next;
    item_t              a_item_reg;
    logic [SQ_W-1:0]    a_dx2_reg, a_dy2_reg;
    logic               b_valid_reg, b_valid_next;
    logic               b_load, a_adv;
    logic [SQ_W:0]      dist2;
    logic               in_circle;
    logic [COLOR_W-1:0] color;

    assign b_load = !b_valid_reg || out_ready;
    assign a_adv  = !a_valid_reg || b_load;
    assign pop    = q_valid && a_adv;

    // Square the radius once per cycle
    always_ff @(posedge clk)
    begin
        r2_reg <= cfg.radius * cfg.radius;
    end

    // Stage A: square the deltas
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_item_reg <= q_item;
            a_dx2_reg  <= SQ_W'(q_item.dx * q_item.dx);
            a_dy2_reg  <= SQ_W'(q_item.dy * q_item.dy);
        end
    end

    // Stage B: compare and choose the color
    assign dist2     = {1'b0, a_dx2_reg} + {1'b0, a_dy2_reg};
    assign in_circle = dist2 < {{(SQ_W + 1 - R2_W){1'b0}}, r2_reg};

    always_comb
    begin
        case (cfg.fill_mode)
            MODE_NORMAL:  color = in_circle ? cfg.fill_color : a_item_reg.old;
            MODE_INVERSE: color = in_circle ? ~a_item_reg.old : a_item_reg.old;
            default:      color = in_circle ? cfg.fill_color : cfg.outer_color;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_load)
        begin
            out_x      <= a_item_reg.x;
            out_y      <= a_item_reg.y;
            out_color  <= color;
            out_inside <= in_circle;
            out_last   <= a_item_reg.last;
        end
    end

    // Hold or advance the stage valids
    always_comb
    begin
        a_valid_next = a_adv ? q_valid : a_valid_reg;
        b_valid_next = b_load ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    assign out_valid = b_valid_reg;

    a_inside_needs_radius : assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && in_circle) |-> (r2_reg != '0))
        else $error("pixel inside a circle of zero radius");
    a_stage_a_kept : assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_load) |=> a_valid_reg)
        else $error("stage A transaction lost under stall");
    a_pop_only_with_data : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop without queued transaction");

endmodule

`default_nettype wire
